@@ design/rsid_pkg.sv @@
// Package for the instruction decoder: operation codes, opcodes and the decode result type.
`default_nettype none

package rsid_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegW  = 5;
  localparam int unsigned KindW = 5;

  typedef enum logic [KindW-1:0] {
    OPK_UNKNOWN = 5'd0,
    OPK_J       = 5'd1,
    OPK_JAL     = 5'd2,
    OPK_BNF     = 5'd3,
    OPK_BF      = 5'd4,
    OPK_NOP     = 5'd5,
    OPK_MOVHI   = 5'd6,
    OPK_JR      = 5'd7,
    OPK_LWZ     = 5'd8,
    OPK_ADDI    = 5'd9,
    OPK_ORI     = 5'd10,
    OPK_SW      = 5'd11,
    OPK_ADD     = 5'd12,
    OPK_SUB     = 5'd13,
    OPK_SFEQ    = 5'd14,
    OPK_SFNE    = 5'd15,
    OPK_SFGES   = 5'd16
  } op_kind_e;

  localparam logic [5:0] OPC_J     = 6'h00;
  localparam logic [5:0] OPC_JAL   = 6'h01;
  localparam logic [5:0] OPC_BNF   = 6'h03;
  localparam logic [5:0] OPC_BF    = 6'h04;
  localparam logic [5:0] OPC_NOP   = 6'h05;
  localparam logic [5:0] OPC_MOVHI = 6'h06;
  localparam logic [5:0] OPC_JR    = 6'h11;
  localparam logic [5:0] OPC_LWZ   = 6'h21;
  localparam logic [5:0] OPC_ADDI  = 6'h27;
  localparam logic [5:0] OPC_ORI   = 6'h2A;
  localparam logic [5:0] OPC_SW    = 6'h35;
  localparam logic [5:0] OPC_ALU   = 6'h38;
  localparam logic [5:0] OPC_SF    = 6'h39;

  localparam logic [1:0] NOP_SUB     = 2'b01;
  localparam logic [3:0] ALU_FN_ADD  = 4'h0;
  localparam logic [3:0] ALU_FN_SUB  = 4'h2;
  localparam logic [4:0] SF_FN_EQ    = 5'h00;
  localparam logic [4:0] SF_FN_NE    = 5'h01;
  localparam logic [4:0] SF_FN_GES   = 5'h0B;

  typedef struct packed {
    op_kind_e          kind;
    logic [RegW-1:0]   dest;
    logic [RegW-1:0]   src_a;
    logic [RegW-1:0]   src_b;
    logic [WordW-1:0]  imm;
    logic [WordW-1:0]  target;
  } dec_t;

endpackage

`default_nettype wire

@@ design/rsid_decode.sv @@
// Combinational decode of one instruction word and its address into a decode result.
`default_nettype none

module rsid_decode
  import rsid_pkg::*;
(
  input  logic [WordW-1:0] word_i,
  input  logic [WordW-1:0] addr_i,
  output dec_t             dec_o
);

  logic [5:0]       opc;
  logic [RegW-1:0]  rd;
  logic [RegW-1:0]  ra;
  logic [RegW-1:0]  rb;
  logic [WordW-1:0] rel_tgt;
  logic [WordW-1:0] simm;
  logic [WordW-1:0] sw_imm;

  assign opc     = word_i[31:26];
  assign rd      = word_i[25:21];
  assign ra      = word_i[20:16];
  assign rb      = word_i[15:11];
  assign rel_tgt = addr_i + {{4{word_i[25]}}, word_i[25:0], 2'b00};
  assign simm    = {{16{word_i[15]}}, word_i[15:0]};
  assign sw_imm  = {{16{rd[4]}}, rd, word_i[10:0]};

  always_comb begin
    dec_o = '0;
    dec_o.kind = OPK_UNKNOWN;
    case (opc)
      OPC_J: begin
        dec_o.kind   = OPK_J;
        dec_o.target = rel_tgt;
      end
      OPC_JAL: begin
        dec_o.kind   = OPK_JAL;
        dec_o.target = rel_tgt;
      end
      OPC_BNF: begin
        dec_o.kind   = OPK_BNF;
        dec_o.target = rel_tgt;
      end
      OPC_BF: begin
        dec_o.kind   = OPK_BF;
        dec_o.target = rel_tgt;
      end
      OPC_NOP: begin
        if (word_i[25:24] == NOP_SUB) begin
          dec_o.kind = OPK_NOP;
        end
      end
      OPC_MOVHI: begin
        if (!word_i[16]) begin
          dec_o.kind = OPK_MOVHI;
          dec_o.dest = rd;
          dec_o.imm  = {word_i[15:0], 16'h0000};
        end
      end
      OPC_JR: begin
        dec_o.kind  = OPK_JR;
        dec_o.src_b = rb;
      end
      OPC_LWZ: begin
        dec_o.kind  = OPK_LWZ;
        dec_o.dest  = rd;
        dec_o.src_a = ra;
        dec_o.imm   = simm;
      end
      OPC_ADDI: begin
        dec_o.kind  = OPK_ADDI;
        dec_o.dest  = rd;
        dec_o.src_a = ra;
        dec_o.imm   = simm;
      end
      OPC_ORI: begin
        dec_o.kind  = OPK_ORI;
        dec_o.dest  = rd;
        dec_o.src_a = ra;
        dec_o.imm   = {16'h0000, word_i[15:0]};
      end
      OPC_SW: begin
        dec_o.kind  = OPK_SW;
        dec_o.src_a = ra;
        dec_o.src_b = rb;
        dec_o.imm   = sw_imm;
      end
      OPC_ALU: begin
        if (word_i[9:8] == 2'b00 &&
            (word_i[3:0] == ALU_FN_ADD || word_i[3:0] == ALU_FN_SUB)) begin
          dec_o.kind  = (word_i[3:0] == ALU_FN_ADD) ? OPK_ADD : OPK_SUB;
          dec_o.dest  = rd;
          dec_o.src_a = ra;
          dec_o.src_b = rb;
        end
      end
      OPC_SF: begin
        if (rd == SF_FN_EQ || rd == SF_FN_NE || rd == SF_FN_GES) begin
          case (rd)
            SF_FN_EQ: dec_o.kind = OPK_SFEQ;
            SF_FN_NE: dec_o.kind = OPK_SFNE;
            default:  dec_o.kind = OPK_SFGES;
          endcase
          dec_o.src_a = ra;
          dec_o.src_b = rb;
        end
      end
      default: begin
        dec_o.kind = OPK_UNKNOWN;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/risc_subset_instruction_decoder.sv @@
// Top level of the instruction decoder: input register, decode logic and result register.
//
//   Channel | Valid       | Ready       | Payload
//   --------+-------------+-------------+---------------------------------------------
//   input   | in_valid_i  | in_ready_o  | insn_word_i, insn_addr_i
//   result  | out_valid_o | out_ready_i | op_kind_o, dest_reg_o, src_a_reg_o,
//           |             |             | src_b_reg_o, imm_value_o, branch_target_o
//
// A request is accepted every cycle while the result is not stalled; it passes through the input
// register and then the result register before it is presented, with the decode logic and the
// 32-bit target adder between the two registers.
// Reset clears both valid flags; payload registers are not reset.
// When the result is stalled, each stage holds and takes a new request only once it empties.
`default_nettype none

module risc_subset_instruction_decoder
  import rsid_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] insn_word_i,
  input  logic [WordW-1:0] insn_addr_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KindW-1:0] op_kind_o,
  output logic [RegW-1:0]  dest_reg_o,
  output logic [RegW-1:0]  src_a_reg_o,
  output logic [RegW-1:0]  src_b_reg_o,
  output logic [WordW-1:0] imm_value_o,
  output logic [WordW-1:0] branch_target_o
);

  logic             in_v_q;
  logic [WordW-1:0] word_q;
  logic [WordW-1:0] addr_q;
  logic             res_v_q;
  dec_t             res_q;
  dec_t             res_d;
  logic             res_ready;

  assign res_ready  = !res_v_q || out_ready_i;
  assign in_ready_o = !in_v_q || res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= insn_word_i;
      addr_q <= insn_addr_i;
    end
  end

  rsid_decode u_decode (
    .word_i (word_q),
    .addr_i (addr_q),
    .dec_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (res_ready) begin
      res_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && in_v_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_v_q;
  assign op_kind_o       = res_q.kind;
  assign dest_reg_o      = res_q.dest;
  assign src_a_reg_o     = res_q.src_a;
  assign src_b_reg_o     = res_q.src_b;
  assign imm_value_o     = res_q.imm;
  assign branch_target_o = res_q.target;

`ifndef SYNTHESIS
  a_unknown_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && op_kind_o == OPK_UNKNOWN) |->
      (dest_reg_o == '0 && src_a_reg_o == '0 && src_b_reg_o == '0 &&
       imm_value_o == '0 && branch_target_o == '0))
    else $error("Unknown operation carries non-zero fields.");

  a_target_only_jumps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && branch_target_o != '0) |->
      (op_kind_o == OPK_J || op_kind_o == OPK_JAL ||
       op_kind_o == OPK_BNF || op_kind_o == OPK_BF))
    else $error("Branch target set for a non-branch operation.");

  a_input_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !res_ready) |=> (in_v_q && $stable(word_q) && $stable(addr_q)))
    else $error("Input stage lost a request while the result stage was full.");

  a_stage_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && res_ready) |=> res_v_q)
    else $error("Request in the input stage did not reach the result stage.");
`endif

endmodule

`default_nettype wire
